@@ src/csf_pkg.sv @@
package csf_pkg;

    // Fixed field widths.
    localparam int BIN_W     = 16;
    localparam int SPAN_W    = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    // Defaults for the top-level parameters.
    localparam int MAX_BINS_DEF    = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] MIN_WHITESPACE_RST = 13'd1;
    localparam logic [CFG_W-1:0] MIN_CONTENT_RST    = 13'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_WHITESPACE = 1'b0,
        CFG_MIN_CONTENT    = 1'b1
    } t_cfg_idx;

    // Up to two spans produced by one histogram bin.
    typedef struct packed {
        logic              two;
        logic [SPAN_W-1:0] begin0;
        logic [SPAN_W-1:0] end0;
        logic [SPAN_W-1:0] begin1;
        logic [SPAN_W-1:0] end1;
    } t_span_pair;

endpackage

@@ src/csf_bin_if.sv @@
interface csf_bin_if;
    logic                        valid;
    logic                        ready;
    logic [csf_pkg::BIN_W-1:0]   bin_count;
    logic                        last_bin;

    modport source (output valid, output bin_count, output last_bin, input ready);
    modport sink   (input valid, input bin_count, input last_bin, output ready);
endinterface

@@ src/csf_span_if.sv @@
interface csf_span_if;
    logic                        valid;
    logic                        ready;
    logic [csf_pkg::SPAN_W-1:0]  span_begin;
    logic [csf_pkg::SPAN_W-1:0]  span_end;
    logic                        last_of_run;

    modport source (output valid, output span_begin, output span_end, output last_of_run,
                    input ready);
    modport sink   (input valid, input span_begin, input span_end, input last_of_run,
                    output ready);
endinterface

@@ src/csf_front.sv @@
module csf_front #(
    parameter int MAX_BINS = csf_pkg::MAX_BINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [csf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [csf_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_bin_valid,
    input  logic [csf_pkg::BIN_W-1:0]     i_bin_count,
    input  logic                          i_last_bin,
    output logic                          o_bin_ready,
    output logic                          o_push,
    output csf_pkg::t_span_pair           o_pair,
    input  logic                          i_push_ready
);

    localparam int PW = $clog2(MAX_BINS + 1);
    localparam int EW = (PW > csf_pkg::SPAN_W) ? PW : csf_pkg::SPAN_W;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_BINS);

    logic [csf_pkg::CFG_W-1:0] r_min_ws, n_min_ws;
    logic [csf_pkg::CFG_W-1:0] r_min_content, n_min_content;
    logic [PW-1:0]             r_position, n_position;
    logic [PW-1:0]             r_block_begin, n_block_begin;
    logic [PW-1:0]             r_block_end, n_block_end;
    logic                      r_block_open, n_block_open;
    logic                      r_in_content, n_in_content;

    logic          accept;
    logic          content;
    logic          start_new;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] upd_begin;
    logic [PW-1:0] upd_end;
    logic          upd_open;
    logic [EW-1:0] gap_e;
    logic [EW-1:0] width_old_e;
    logic [EW-1:0] width_new_e;
    logic [EW-1:0] min_ws_e;
    logic [EW-1:0] min_content_e;
    logic          emit_old;
    logic          emit_new;

    // Masks a position to the span field width.
    function automatic logic [csf_pkg::SPAN_W-1:0] to_span(input logic [PW-1:0] pos);
        logic [EW-1:0] ext;
        ext = EW'(pos);
        return ext[csf_pkg::SPAN_W-1:0];
    endfunction

    assign accept      = i_bin_valid && i_push_ready;
    assign o_bin_ready = i_push_ready;

    // Classify the bin and decide which blocks close.
    always_comb begin
        content  = (i_bin_count != '0);
        pos_next = (r_position == POS_MAX) ? r_position : r_position + 1'b1;

        gap_e         = EW'(r_position - r_block_end);
        min_ws_e      = EW'(r_min_ws);
        min_content_e = EW'(r_min_content);
        width_old_e   = EW'(r_block_end - r_block_begin);

        start_new = content && !r_in_content && (!r_block_open || (gap_e >= min_ws_e));
        emit_old  = start_new && r_block_open && (width_old_e != '0) &&
                    (width_old_e >= min_content_e);

        upd_begin = start_new ? r_position : r_block_begin;
        upd_end   = content ? pos_next : r_block_end;
        upd_open  = r_block_open || start_new;

        width_new_e = EW'(upd_end - upd_begin);
        emit_new    = i_last_bin && upd_open && (width_new_e != '0) &&
                      (width_new_e >= min_content_e);
    end

    // Pack the spans, older block first.
    always_comb begin
        o_push        = accept && (emit_old || emit_new);
        o_pair.two    = emit_old && emit_new;
        o_pair.begin0 = emit_old ? to_span(r_block_begin) : to_span(upd_begin);
        o_pair.end0   = emit_old ? to_span(r_block_end) : to_span(upd_end);
        o_pair.begin1 = to_span(upd_begin);
        o_pair.end1   = to_span(upd_end);
    end

    // Next state of the block tracker and the configuration registers.
    always_comb begin
        n_min_ws      = r_min_ws;
        n_min_content = r_min_content;
        n_position    = r_position;
        n_block_begin = r_block_begin;
        n_block_end   = r_block_end;
        n_block_open  = r_block_open;
        n_in_content  = r_in_content;

        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                csf_pkg::CFG_MIN_WHITESPACE: n_min_ws      = i_cfg_wdata;
                csf_pkg::CFG_MIN_CONTENT:    n_min_content = i_cfg_wdata;
                default: ;
            endcase
        end

        if (accept) begin
            if (i_last_bin) begin
                n_position    = '0;
                n_block_begin = '0;
                n_block_end   = '0;
                n_block_open  = 1'b0;
                n_in_content  = 1'b0;
            end else begin
                n_position    = pos_next;
                n_block_begin = upd_begin;
                n_block_end   = upd_end;
                n_block_open  = upd_open;
                n_in_content  = content;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ws      <= csf_pkg::MIN_WHITESPACE_RST;
            r_min_content <= csf_pkg::MIN_CONTENT_RST;
            r_position    <= '0;
            r_block_begin <= '0;
            r_block_end   <= '0;
            r_block_open  <= 1'b0;
            r_in_content  <= 1'b0;
        end else begin
            r_min_ws      <= n_min_ws;
            r_min_content <= n_min_content;
            r_position    <= n_position;
            r_block_begin <= n_block_begin;
            r_block_end   <= n_block_end;
            r_block_open  <= n_block_open;
            r_in_content  <= n_in_content;
        end
    end

`ifndef NO_ASSERTIONS
    // The position saturates and never runs past the histogram limit.
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= POS_MAX)
        else $error("position beyond MAX_BINS");

    // A block never ends past the current position nor before its own begin.
    a_block_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_block_end <= r_position) && (r_block_begin <= r_block_end))
        else $error("block bounds out of order");

    // Two spans from one bin only happen on the last bin.
    a_two_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_pair.two) |-> i_last_bin)
        else $error("two spans without last bin");
`endif

endmodule

@@ src/csf_queue.sv @@
module csf_queue #(
    parameter int DEPTH = csf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  csf_pkg::t_span_pair i_pair,
    output logic                o_push_ready,
    output logic                o_head_valid,
    output csf_pkg::t_span_pair o_head,
    input  logic                i_pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    csf_pkg::t_span_pair r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_head_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

`ifndef NO_ASSERTIONS
    // The fill count stays within the queue depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count overflow");

    // Pointers agree with the fill count when the queue is empty or full.
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == '0) || (r_count == CNT_FULL)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

@@ src/csf_back.sv @@
module csf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  csf_pkg::t_span_pair        i_head,
    output logic                       o_pop,
    output logic                       o_span_valid,
    output logic [csf_pkg::SPAN_W-1:0] o_span_begin,
    output logic [csf_pkg::SPAN_W-1:0] o_span_end,
    output logic                       o_last_of_run,
    input  logic                       i_span_ready
);

    // Set while the second span of the head entry is on offer.
    logic r_second, n_second;
    logic take;

    // Select the span of the head entry that is on offer.
    always_comb begin
        o_span_valid  = i_head_valid;
        o_span_begin  = r_second ? i_head.begin1 : i_head.begin0;
        o_span_end    = r_second ? i_head.end1 : i_head.end0;
        o_last_of_run = r_second || !i_head.two;
        take          = i_head_valid && i_span_ready;
        o_pop         = take && o_last_of_run;
    end

    // Step to the second span or on to the next entry.
    always_comb begin
        n_second = r_second;
        if (take) begin
            n_second = !o_last_of_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

`ifndef NO_ASSERTIONS
    // The second span is only offered for a valid two-span entry.
    a_second_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (i_head_valid && i_head.two))
        else $error("second span without a two-span entry");
`endif

endmodule

@@ src/content_span_finder.sv @@
// Content span finder: takes one projection-histogram bin per request and reports
// the content blocks of the histogram as spans [begin, end). Gaps of zero bins
// shorter than the minimum whitespace width are bridged; a block is closed by a
// long enough gap or by the last bin and is reported if it is at least the minimum
// content width wide. The front end classifies a bin and updates the block
// tracker in the cycle it accepts it, so one bin is accepted every clock cycle
// as long as the span queue (QUEUE_DEPTH entries) has room. The spans of a bin go
// into the queue as one entry when the bin is accepted and are offered on the
// output in order, older block first. Positions count to MAX_BINS and stay there.
// The user must write configuration through the plain write port only while the
// block is idle; the block itself does not enforce this.
module content_span_finder #(
    parameter int MAX_BINS    = csf_pkg::MAX_BINS_DEF,
    parameter int QUEUE_DEPTH = csf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [csf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [csf_pkg::CFG_W-1:0]     i_cfg_wdata,
    csf_bin_if.sink                       i_bin,
    csf_span_if.source                    o_span
);

    logic                push;
    logic                push_ready;
    csf_pkg::t_span_pair pair;
    logic                head_valid;
    csf_pkg::t_span_pair head;
    logic                pop;

    csf_front #(
        .MAX_BINS (MAX_BINS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_bin_valid  (i_bin.valid),
        .i_bin_count  (i_bin.bin_count),
        .i_last_bin   (i_bin.last_bin),
        .o_bin_ready  (i_bin.ready),
        .o_push       (push),
        .o_pair       (pair),
        .i_push_ready (push_ready)
    );

    csf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pair       (pair),
        .o_push_ready (push_ready),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    csf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_span_valid  (o_span.valid),
        .o_span_begin  (o_span.span_begin),
        .o_span_end    (o_span.span_end),
        .o_last_of_run (o_span.last_of_run),
        .i_span_ready  (o_span.ready)
    );

endmodule

@@ tb/sv/content_span_finder_tb.sv @@
`timescale 1ns / 100ps

module content_span_finder_tb;

    localparam int BIN_LIMIT = csf_pkg::MAX_BINS_DEF;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [csf_pkg::SPAN_W-1:0] span_begin;
        logic [csf_pkg::SPAN_W-1:0] span_end;
        logic                       last_of_run;
    } t_span;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [csf_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [csf_pkg::CFG_W-1:0]     i_cfg_wdata;

    csf_bin_if  bin_if ();
    csf_span_if span_if ();

    content_span_finder #(
        .MAX_BINS(BIN_LIMIT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_bin       (bin_if),
        .o_span      (span_if)
    );

    // Spans that the accepted bins must produce, oldest first.
    t_span expected_spans[$];

    // Shadow of the block tracker and its registers.
    int unsigned min_gap;
    int unsigned min_width;
    int unsigned bin_pos;
    int unsigned blk_begin;
    int unsigned blk_end;
    bit          blk_open;
    bit          in_run;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned err_count;
    int unsigned n_bins;
    int unsigned n_hists;
    int unsigned n_spans;
    int unsigned n_cfg_writes;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #5_000_000;
        $display("** content_span_finder: FAILED **");
        $finish;
    end

    // The receiver stalls at random on the falling edge.
    always @(negedge i_clk) begin
        span_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare every accepted span with the oldest expectation.
    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n && span_if.valid && span_if.ready) begin
            n_spans++;
            if (expected_spans.size() == 0) begin
                $error("unexpected span: begin %0d, end %0d, last_of_run %0d",
                       span_if.span_begin, span_if.span_end, span_if.last_of_run);
                err_count++;
            end else begin
                want = expected_spans.pop_front();
                if (span_if.span_begin !== want.span_begin) begin
                    $error("span_begin: expected %0d, actual %0d",
                           want.span_begin, span_if.span_begin);
                    err_count++;
                end
                if (span_if.span_end !== want.span_end) begin
                    $error("span_end: expected %0d, actual %0d",
                           want.span_end, span_if.span_end);
                    err_count++;
                end
                if (span_if.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last_of_run, span_if.last_of_run);
                    err_count++;
                end
            end
        end
    end

    // Clear the tracker, as the last bin of a histogram does.
    function automatic void clear_tracker();
        bin_pos   = 0;
        blk_begin = 0;
        blk_end   = 0;
        blk_open  = 1'b0;
        in_run    = 1'b0;
    endfunction

    // A block is reported only when it exists, is not empty and is wide enough.
    function automatic bit block_reportable();
        int unsigned width;
        width = blk_end - blk_begin;
        return blk_open && (width != 0) && (width >= min_width);
    endfunction

    // Work out the spans caused by one accepted bin.
    task automatic predict_spans(input logic [csf_pkg::BIN_W-1:0] cnt, input logic lst);
        t_span       found[$];
        t_span       item;
        int unsigned nxt;
        nxt = (bin_pos < BIN_LIMIT) ? bin_pos + 1 : BIN_LIMIT;
        if (cnt != '0) begin
            // A new run after a long enough gap closes the previous block.
            if (!in_run && (!blk_open || (bin_pos - blk_end) >= min_gap)) begin
                if (block_reportable()) begin
                    item = '{csf_pkg::SPAN_W'(blk_begin), csf_pkg::SPAN_W'(blk_end), 1'b0};
                    found.push_back(item);
                end
                blk_begin = bin_pos;
                blk_open  = 1'b1;
            end
            in_run  = 1'b1;
            blk_end = nxt;
        end else begin
            in_run = 1'b0;
        end
        bin_pos = nxt;
        if (lst) begin
            if (block_reportable()) begin
                item = '{csf_pkg::SPAN_W'(blk_begin), csf_pkg::SPAN_W'(blk_end), 1'b0};
                found.push_back(item);
            end
            clear_tracker();
        end
        if (found.size() > 0)
            found[found.size()-1].last_of_run = 1'b1;
        foreach (found[k])
            expected_spans.push_back(found[k]);
    endtask

    // Send one bin request; called and returns at a falling edge.
    task automatic send_bin(input logic [csf_pkg::BIN_W-1:0] cnt, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            bin_if.valid = 1'b0;
            @(negedge i_clk);
        end
        bin_if.valid     = 1'b1;
        bin_if.bin_count = cnt;
        bin_if.last_bin  = lst;
        @(posedge i_clk);
        while (!bin_if.ready)
            @(posedge i_clk);
        predict_spans(cnt, lst);
        n_bins++;
        if (lst)
            n_hists++;
        @(negedge i_clk);
    endtask

    // Drop the request and wait until the block has drained.
    task automatic wait_idle();
        bin_if.valid = 1'b0;
        while (expected_spans.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register; the block must be idle.
    task automatic write_cfg(input csf_pkg::t_cfg_idx idx, input int unsigned value);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = csf_pkg::CFG_W'(value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        if (idx == csf_pkg::CFG_MIN_WHITESPACE)
            min_gap = value & ((1 << csf_pkg::CFG_W) - 1);
        else
            min_width = value & ((1 << csf_pkg::CFG_W) - 1);
        n_cfg_writes++;
    endtask

    // Length of the next content run or zero gap; gaps cluster around the threshold.
    function automatic int unsigned next_run_len(input bit content);
        int unsigned cap;
        if (content)
            return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
        cap = (min_gap > 10) ? 10 : min_gap;
        return $urandom_range(1, cap + 2);
    endfunction

    // One histogram of alternating runs, or of random bins when noisy.
    task automatic send_histogram(input int unsigned len, input bit noisy);
        bit                          content;
        int unsigned                 left;
        logic [csf_pkg::BIN_W-1:0]   cnt;
        content = ($urandom_range(0, 1) == 1);
        left    = next_run_len(content);
        for (int unsigned i = 0; i < len; i++) begin
            if (noisy) begin
                content = ($urandom_range(0, 1) == 1);
            end else if (left == 0) begin
                content = !content;
                left    = next_run_len(content);
            end
            left--;
            if (!content)
                cnt = '0;
            else begin
                case ($urandom_range(0, 7))
                    0:       cnt = 16'h0001;
                    1:       cnt = 16'hFFFF;
                    default: cnt = csf_pkg::BIN_W'($urandom_range(1, 65535));
                endcase
            end
            send_bin(cnt, i == len - 1);
        end
    endtask

    // Reset register values: separation by one zero, one-bin blocks reported.
    task automatic test_reset_defaults();
        send_idle_pct = 22;
        recv_idle_pct = 55;
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'h0001, 1'b0);
        send_bin(16'h8000, 1'b1);
        // New run on the last bin reports the old block and the new one.
        send_bin(16'h0001, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'h1234, 1'b1);
        // A last bin with no open block reports nothing.
        send_bin(16'h0000, 1'b1);
        wait_idle();
    endtask

    // Zero gap width, the register extremes and bridged gaps.
    task automatic test_corner_cases();
        write_cfg(csf_pkg::CFG_MIN_WHITESPACE, 0);
        write_cfg(csf_pkg::CFG_MIN_CONTENT, 1);
        send_bin(16'h0001, 1'b0);
        send_bin(16'h0001, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'h0005, 1'b1);
        wait_idle();
        write_cfg(csf_pkg::CFG_MIN_WHITESPACE, 4096);
        write_cfg(csf_pkg::CFG_MIN_CONTENT, 4096);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'h0001, 1'b1);
        wait_idle();
        write_cfg(csf_pkg::CFG_MIN_WHITESPACE, 2);
        write_cfg(csf_pkg::CFG_MIN_CONTENT, 2);
        send_bin(16'h0001, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'h0001, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'h0001, 1'b0);
        send_bin(16'h0001, 1'b1);
        wait_idle();
    endtask

    // Random histograms under random register settings.
    task automatic test_random(input int unsigned s_pct, input int unsigned r_pct,
                               input int unsigned n_items);
        int unsigned start;
        int unsigned pick;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = n_bins;
        while (n_bins - start < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_cfg(csf_pkg::CFG_MIN_WHITESPACE, 4096);
            else if (pick == 1)
                write_cfg(csf_pkg::CFG_MIN_WHITESPACE, $urandom_range(0, 4096));
            else
                write_cfg(csf_pkg::CFG_MIN_WHITESPACE, $urandom_range(0, 6));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_cfg(csf_pkg::CFG_MIN_CONTENT, 4096);
            else if (pick == 1)
                write_cfg(csf_pkg::CFG_MIN_CONTENT, $urandom_range(1, 4096));
            else
                write_cfg(csf_pkg::CFG_MIN_CONTENT, $urandom_range(1, 6));
            repeat ($urandom_range(3, 8)) begin
                send_histogram(($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                           : $urandom_range(1, 20),
                               $urandom_range(0, 4) == 0);
            end
            wait_idle();
        end
    endtask

    // Reset, then the tests in turn, then the verdict.
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_index      = csf_pkg::CFG_MIN_WHITESPACE;
        i_cfg_wdata      = '0;
        bin_if.valid     = 1'b0;
        bin_if.bin_count = '0;
        bin_if.last_bin  = 1'b0;
        span_if.ready    = 1'b0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        err_count        = 0;
        n_bins           = 0;
        n_hists          = 0;
        n_spans          = 0;
        n_cfg_writes     = 0;
        min_gap          = csf_pkg::MIN_WHITESPACE_RST;
        min_width        = csf_pkg::MIN_CONTENT_RST;
        clear_tracker();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_corner_cases();
        test_random(22, 55, 600);
        test_random(55, 22, 600);
        test_random(0, 0, 600);

        wait_idle();
        if (expected_spans.size() != 0) begin
            $error("%0d expected spans never arrived", expected_spans.size());
            err_count++;
        end
        $display("Ran %0d bins in %0d histograms with %0d register writes; %0d spans checked.",
                 n_bins, n_hists, n_cfg_writes, n_spans);
        $display("Covered reset values, register extremes, bridged gaps and three stall mixes.");
        if (err_count == 0)
            $display("** content_span_finder: PASSED **");
        else
            $display("** content_span_finder: FAILED **");
        $finish;
    end

endmodule
